@@ hw/rtl/tst_pkg.sv @@
// ---------------------------------------------------------------------------
// Totient sieve table package
// Shared widths, table size and the controller-to-datapath command set.
// ---------------------------------------------------------------------------
`default_nettype none

package tst_pkg;

    localparam int TABLE_SIZE = 65536;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int VAL_W      = 16;
    localparam int LIMIT_W    = 17;
    // Largest limit honoured: the table depth, and never more than a 16-bit index reaches.
    localparam int CAP        = (TABLE_SIZE < 65536) ? TABLE_SIZE : 65536;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65536);

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH_QUERY,
        DP_INIT_START,
        DP_INIT_WR,
        DP_SIEVE_START,
        DP_MARK_RD,
        DP_NEXT_I,
        DP_INV_START,
        DP_INV_A,
        DP_INV_B,
        DP_PHI_RD,
        DP_PHI_QUO,
        DP_PHI_WR,
        DP_QUERY_RD,
        DP_LOAD_OUT
    } t_dp_op;

    typedef struct packed {
        logic init_done;
        logic sieve_done;
        logic row_done;
        logic marked;
        logic inv_last;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ hw/rtl/tst_query_if.sv @@
// ---------------------------------------------------------------------------
// Query channel
// Carries one query word: the index whose totient is wanted.
// ---------------------------------------------------------------------------
`default_nettype none

interface tst_query_if;
    logic        valid;
    logic        ready;
    logic [15:0] query_index;

    modport source (output valid, output query_index, input ready);
    modport sink   (input valid, input query_index, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tst_result_if.sv @@
// ---------------------------------------------------------------------------
// Result channel
// Carries one result word: the totient and the in-range flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface tst_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] totient_value;
    logic        index_in_range;

    modport source (output valid, output totient_value, output index_in_range, input ready);
    modport sink   (input valid, input totient_value, input index_in_range, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/totient_sieve_table.sv @@
// ---------------------------------------------------------------------------
// Totient sieve table
// Answers queries for Euler's totient from a table built by a sieve.
// ---------------------------------------------------------------------------
// The block keeps a table of phi(k) for k below the configured limit and
// answers each query word with one result word. The table is built on the
// first query after reset or after a write to the limit register; that
// query waits for the whole build. The build runs on one read and one write
// port of the table memory: it preloads phi(k) = k into each entry, reads
// and checks the mark of each index scanned for primality, forms the
// inverse of each prime modulo 2^16 in Newton steps, and for each multiple
// of that prime reads, forms the quotient and writes back, then closes the
// prime's row. Once the table is built, an accepted query passes through
// the registered memory read and the output register before its result
// word is valid. A new query is taken when the result word has left or is
// leaving. A query at or above the limit returns a totient of zero with
// the in-range flag low. The limit saturates at 65536.
// ---------------------------------------------------------------------------
`default_nettype none

module totient_sieve_table (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    tst_query_if.sink                  i_query,
    tst_result_if.source               o_result,
    input  wire                        i_cfg_wr_en,
    input  wire [tst_pkg::LIMIT_W-1:0] i_cfg_wr_data
);
    import tst_pkg::*;

    // The controller issues one datapath command per cycle and steers its
    // loops from the status flags that come back.
    t_dp_op  cmd;
    t_dp_sts sts;

    tst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_query.valid),
        .o_in_ready  (i_query.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds both table memories, the limit register and the
    // result word register.
    tst_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_query_index    (i_query.query_index),
        .o_totient_value  (o_result.totient_value),
        .o_index_in_range (o_result.index_in_range)
    );

endmodule

`default_nettype wire

@@ hw/rtl/tst_datapath.sv @@
// ---------------------------------------------------------------------------
// Totient sieve datapath
// Table memories, sieve counters, inverse and quotient arithmetic, limit
// register and the result word register.
// ---------------------------------------------------------------------------
`default_nettype none

module tst_datapath (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  tst_pkg::t_dp_op           i_cmd,
    output tst_pkg::t_dp_sts          o_sts,
    input  wire                       i_cfg_wr_en,
    input  wire [tst_pkg::LIMIT_W-1:0] i_cfg_wr_data,
    input  wire [15:0]                i_query_index,
    output logic [15:0]               o_totient_value,
    output logic                      o_index_in_range
);
    import tst_pkg::*;

    logic [VAL_W-1:0] r_phi_mem  [TABLE_SIZE];
    logic             r_mark_mem [TABLE_SIZE];

    logic [LIMIT_W-1:0] r_limit;
    logic [LIMIT_W-1:0] r_i;
    logic [LIMIT_W-1:0] r_j;
    logic [15:0]        r_query;
    logic [VAL_W-1:0]   r_phi_rd;
    logic               r_mark_rd;
    logic [VAL_W-1:0]   r_inv;
    logic [VAL_W-1:0]   r_t;
    logic [1:0]         r_iter;
    logic [VAL_W-1:0]   r_quo;
    logic [15:0]        r_out_value;
    logic               r_out_range;

    logic [LIMIT_W-1:0]  n_limit_eff;
    logic [VAL_W-1:0]    p_val;
    logic [2*VAL_W-1:0]  inv_prod_a;
    logic [2*VAL_W-1:0]  inv_prod_b;
    logic [2*VAL_W-1:0]  quo_prod;
    logic [VAL_W-1:0]    quo_val;
    logic                in_range;

    logic               phi_we;
    logic [ADDR_W-1:0]  phi_waddr;
    logic [VAL_W-1:0]   phi_wdata;
    logic               phi_re;
    logic [ADDR_W-1:0]  phi_raddr;
    logic               mark_we;
    logic               mark_wdata;

    assign n_limit_eff = (r_limit > LIMIT_W'(CAP)) ? LIMIT_W'(CAP) : r_limit;
    assign p_val       = r_i[VAL_W-1:0];

    // Newton step for the inverse of an odd p modulo 2^16: x <- x * (2 - p * x).
    assign inv_prod_a = p_val * r_inv;
    assign inv_prod_b = r_inv * (VAL_W'(2) - r_t);

    // The running entry is always an exact multiple of p, so for odd p the
    // quotient is a product with the modular inverse.
    assign quo_prod = r_phi_rd * r_inv;
    assign quo_val  = (r_i == LIMIT_W'(2)) ? (r_phi_rd >> 1) : quo_prod[VAL_W-1:0];

    assign in_range = {1'b0, r_query} < n_limit_eff;

    always_comb begin
        phi_we     = 1'b0;
        phi_waddr  = r_j[ADDR_W-1:0];
        phi_wdata  = r_j[VAL_W-1:0];
        phi_re     = 1'b0;
        phi_raddr  = r_j[ADDR_W-1:0];
        mark_we    = 1'b0;
        mark_wdata = 1'b0;
        case (i_cmd)
            DP_INIT_WR: begin
                phi_we  = 1'b1;
                mark_we = 1'b1;
            end
            DP_PHI_WR: begin
                phi_we     = 1'b1;
                phi_wdata  = r_phi_rd - r_quo;
                mark_we    = (r_j != r_i);
                mark_wdata = 1'b1;
            end
            DP_PHI_RD: begin
                phi_re = 1'b1;
            end
            DP_QUERY_RD: begin
                phi_re    = 1'b1;
                phi_raddr = r_query[ADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (phi_we) begin
            r_phi_mem[phi_waddr] <= phi_wdata;
        end
        if (phi_re) begin
            r_phi_rd <= r_phi_mem[phi_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_mark_mem[phi_waddr] <= mark_wdata;
        end
        if (i_cmd == DP_MARK_RD) begin
            r_mark_rd <= r_mark_mem[r_i[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            DP_LATCH_QUERY: r_query <= i_query_index;
            DP_INIT_START:  r_j <= '0;
            DP_INIT_WR:     r_j <= r_j + LIMIT_W'(1);
            DP_SIEVE_START: r_i <= LIMIT_W'(2);
            DP_NEXT_I:      r_i <= r_i + LIMIT_W'(1);
            DP_INV_START: begin
                r_inv  <= p_val;
                r_iter <= '0;
                r_j    <= r_i;
            end
            DP_INV_A:       r_t <= inv_prod_a[VAL_W-1:0];
            DP_INV_B: begin
                r_inv  <= inv_prod_b[VAL_W-1:0];
                r_iter <= r_iter + 2'd1;
            end
            DP_PHI_QUO:     r_quo <= quo_val;
            DP_PHI_WR:      r_j <= r_j + r_i;
            DP_LOAD_OUT: begin
                r_out_value <= in_range ? r_phi_rd : 16'd0;
                r_out_range <= in_range;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.init_done  = (r_j >= n_limit_eff);
    assign o_sts.sieve_done = (r_i >= n_limit_eff);
    assign o_sts.row_done   = (r_j >= n_limit_eff);
    assign o_sts.marked     = r_mark_rd;
    assign o_sts.inv_last   = (r_iter == 2'd2);

    assign o_totient_value  = r_out_value;
    assign o_index_in_range = r_out_range;

endmodule

`default_nettype wire

@@ hw/rtl/tst_ctrl.sv @@
// ---------------------------------------------------------------------------
// Totient sieve controller
// Sequences the lazy table build and the query read, and owns the handshake.
// ---------------------------------------------------------------------------
`default_nettype none

module tst_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  wire               i_cfg_wr_en,
    input  tst_pkg::t_dp_sts  i_sts,
    output tst_pkg::t_dp_op   o_cmd
);
    import tst_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT0,
        S_INIT,
        S_MRD,
        S_MCHK,
        S_INVA,
        S_INVB,
        S_JRD,
        S_JQUO,
        S_JWR,
        S_QRD,
        S_QOUT
    } t_state;

    t_state r_state, n_state;
    logic   r_built, n_built;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = o_in_ready && i_in_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_built     = r_built;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd   = DP_LATCH_QUERY;
                    n_state = r_built ? S_QRD : S_INIT0;
                end
            end
            S_INIT0: begin
                o_cmd   = DP_INIT_START;
                n_state = S_INIT;
            end
            S_INIT: begin
                if (i_sts.init_done) begin
                    o_cmd   = DP_SIEVE_START;
                    n_state = S_MRD;
                end else begin
                    o_cmd = DP_INIT_WR;
                end
            end
            S_MRD: begin
                if (i_sts.sieve_done) begin
                    n_built = 1'b1;
                    n_state = S_QRD;
                end else begin
                    o_cmd   = DP_MARK_RD;
                    n_state = S_MCHK;
                end
            end
            S_MCHK: begin
                if (i_sts.marked) begin
                    o_cmd   = DP_NEXT_I;
                    n_state = S_MRD;
                end else begin
                    o_cmd   = DP_INV_START;
                    n_state = S_INVA;
                end
            end
            S_INVA: begin
                o_cmd   = DP_INV_A;
                n_state = S_INVB;
            end
            S_INVB: begin
                o_cmd   = DP_INV_B;
                n_state = i_sts.inv_last ? S_JRD : S_INVA;
            end
            S_JRD: begin
                if (i_sts.row_done) begin
                    o_cmd   = DP_NEXT_I;
                    n_state = S_MRD;
                end else begin
                    o_cmd   = DP_PHI_RD;
                    n_state = S_JQUO;
                end
            end
            S_JQUO: begin
                o_cmd   = DP_PHI_QUO;
                n_state = S_JWR;
            end
            S_JWR: begin
                o_cmd   = DP_PHI_WR;
                n_state = S_JRD;
            end
            S_QRD: begin
                o_cmd   = DP_QUERY_RD;
                n_state = S_QOUT;
            end
            S_QOUT: begin
                o_cmd       = DP_LOAD_OUT;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_wr_en) begin
            n_built = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tst_checker.sv @@
// ---------------------------------------------------------------------------
// Totient sieve table checker
// Port-level assertions on the query and result channels.
// ---------------------------------------------------------------------------
`default_nettype none

module tst_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_q_valid,
    input  wire        i_q_ready,
    input  wire        i_r_valid,
    input  wire        i_r_ready,
    input  wire [15:0] i_r_value,
    input  wire        i_r_range
);

    // A result word out of range always carries a zero totient.
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_r_valid && !i_r_range) |-> (i_r_value == 16'd0))
        else $error("out-of-range result with nonzero totient");

    // One query at a time: after a query word is taken, no other is taken at once.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_valid && i_q_ready) |=> !i_q_ready)
        else $error("query accepted while previous one in flight");

    // A waiting result word stays until it is taken.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_r_valid && !i_r_ready) |=> (i_r_valid && $stable(i_r_value)))
        else $error("result word dropped or changed while stalled");

    // Reset leaves no result word pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_r_valid)
        else $error("result valid after reset");

endmodule

bind totient_sieve_table tst_checker u_tst_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_q_valid (i_query.valid),
    .i_q_ready (i_query.ready),
    .i_r_valid (o_result.valid),
    .i_r_ready (o_result.ready),
    .i_r_value (o_result.totient_value),
    .i_r_range (o_result.index_in_range)
);

`default_nettype wire
